### design/lzwd_pkg.sv
// Shared constants and types for the LZSS window decoder.
// No dependencies; every module file imports this package.
package lzwd_pkg;

	localparam int WIN_AW = 12;
	localparam int FILL_W = WIN_AW + 1;
	localparam int LEN_W = 5;
	localparam int MATCH_BIAS = 2;

	localparam logic [FILL_W-1:0] WIN_DEPTH = 13'd4096;
	localparam logic [WIN_AW-1:0] WP_RESET = 12'd4078;
	localparam logic [7:0] FILL_BYTE = 8'h20;

	// Decoded token for the byte on the input channel.
	typedef struct packed {
		logic literal;
		logic match;
		logic last;
		logic [7:0] data;
		logic [WIN_AW-1:0] pos;
		logic [LEN_W-1:0] len;
	} tok_cmd_t;

	// One write port and one read port on the history window.
	typedef struct packed {
		logic we;
		logic [WIN_AW-1:0] waddr;
		logic [7:0] wdata;
		logic re;
		logic [WIN_AW-1:0] raddr;
	} ram_req_t;

endpackage

### design/lzwd_in_if.sv
// Valid/ready channel carrying compressed bytes into the decoder.
// No dependencies.
interface lzwd_in_if;
	logic valid;
	logic ready;
	logic [7:0] code_byte;
	logic final_byte;

	modport source(output valid, code_byte, final_byte, input ready);
	modport sink(input valid, code_byte, final_byte, output ready);
endinterface

### design/lzwd_out_if.sv
// Valid/ready channel carrying decoded bytes out of the decoder.
// No dependencies.
interface lzwd_out_if;
	logic valid;
	logic ready;
	logic [7:0] plain_byte;
	logic run_end;

	modport source(output valid, plain_byte, run_end, input ready);
	modport sink(input valid, plain_byte, run_end, output ready);
endinterface

### design/lzwd_window_ram.sv
// 4096 x 8 history window: one write port, one registered read port.
// Depends on lzwd_pkg for the request struct and address width.
module lzwd_window_ram
	import lzwd_pkg::*;
(
	input  logic clk,
	input  ram_req_t req,
	output logic [7:0] rdata
);

	logic [7:0] mem [0:(1 << WIN_AW) - 1];

	// Read returns the old contents on a same-address write; the engine forwards.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

### design/lzwd_token_parser.sv
// Flag byte and token state of the LZSS stream; classifies each input byte.
// Depends on lzwd_pkg.
module lzwd_token_parser
	import lzwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] code_byte,
	input  logic final_byte,
	input  logic take,
	output tok_cmd_t cmd
);

	logic [7:0] flags_q;
	logic [3:0] tleft_q;
	logic phase_q;
	logic [7:0] poslow_q;

	always_comb begin
		cmd.literal = (tleft_q != 4'd0) && flags_q[0];
		cmd.match = (tleft_q != 4'd0) && !flags_q[0] && phase_q;
		cmd.last = final_byte;
		cmd.data = code_byte;
		cmd.pos = {code_byte[7:4], poslow_q};
		cmd.len = LEN_W'(code_byte[3:0]) + LEN_W'(MATCH_BIAS + 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			tleft_q <= '0;
			phase_q <= 1'b0;
			poslow_q <= '0;
		end else if (take) begin
			if (final_byte) begin
				flags_q <= '0;
				tleft_q <= '0;
				phase_q <= 1'b0;
				poslow_q <= '0;
			end else if (tleft_q == 4'd0) begin
				flags_q <= code_byte;
				tleft_q <= 4'd8;
				phase_q <= 1'b0;
			end else if (flags_q[0] || phase_q) begin
				// literal or second match byte: token done
				flags_q <= {1'b0, flags_q[7:1]};
				tleft_q <= tleft_q - 4'd1;
				phase_q <= 1'b0;
			end else begin
				poslow_q <= code_byte;
				phase_q <= 1'b1;
			end
		end
	end

endmodule

### design/lzwd_copy_engine.sv
// Copy engine: issues window reads, holds the output stage, writes bytes back.
// Depends on lzwd_pkg; drives lzwd_window_ram through a ram_req_t.
module lzwd_copy_engine
	import lzwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  tok_cmd_t cmd,
	input  logic in_valid,
	output logic in_ready,
	output logic take,
	output logic out_valid,
	input  logic out_ready,
	output logic [7:0] plain_byte,
	output logic run_end,
	output ram_req_t ram_req,
	input  logic [7:0] ram_rdata
);

	logic out_valid_q;
	logic [LEN_W-1:0] left_q;
	logic final_q;
	logic [WIN_AW-1:0] wp_q;
	logic [FILL_W-1:0] fill_q;
	logic [WIN_AW-1:0] rd_addr_q;

	logic fwd_s1;
	logic [7:0] fwd_byte_s1;
	logic vld_s1;
	logic run_end_s1;
	logic final_s1;

	logic adv, fire, start, lit, cont, issue, load;
	logic [WIN_AW-1:0] ra;
	logic [WIN_AW-1:0] ra_off;
	logic issue_fwd, issue_vld;
	logic rewind;

	assign adv = !out_valid_q || out_ready;
	assign fire = out_valid_q && out_ready;
	assign in_ready = (left_q == '0) && adv && !(out_valid_q && final_s1);
	assign take = in_valid && in_ready;
	assign start = take && cmd.match;
	assign lit = take && cmd.literal;
	assign cont = (left_q != '0) && adv;
	assign issue = start || cont;
	assign load = issue || lit;
	assign ra = start ? cmd.pos : rd_addr_q;

	// An entry is valid once written since reset: offset from the reset pointer below fill.
	assign ra_off = ra - WP_RESET;
	assign issue_vld = {1'b0, ra_off} < fill_q;
	// Byte being written this cycle is not yet in the memory read data.
	assign issue_fwd = fire && (ra == wp_q);

	assign plain_byte = fwd_s1 ? fwd_byte_s1 : (vld_s1 ? ram_rdata : FILL_BYTE);
	assign run_end = run_end_s1;
	assign out_valid = out_valid_q;

	assign rewind = (take && cmd.last && !cmd.literal && !cmd.match) ||
		(fire && run_end_s1 && final_s1);

	always_comb begin
		ram_req.we = fire;
		ram_req.waddr = wp_q;
		ram_req.wdata = plain_byte;
		ram_req.re = issue;
		ram_req.raddr = ra;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			left_q <= '0;
			final_q <= 1'b0;
			wp_q <= WP_RESET;
			fill_q <= '0;
		end else begin
			if (adv) begin
				out_valid_q <= load;
			end
			if (start) begin
				left_q <= cmd.len - LEN_W'(1);
				final_q <= cmd.last;
			end else if (cont) begin
				left_q <= left_q - LEN_W'(1);
			end
			if (rewind) begin
				wp_q <= WP_RESET;
				fill_q <= '0;
			end else if (fire) begin
				wp_q <= wp_q + WIN_AW'(1);
				if (fill_q != WIN_DEPTH) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rd_addr_q <= cmd.pos + WIN_AW'(1);
		end else if (cont) begin
			rd_addr_q <= rd_addr_q + WIN_AW'(1);
		end
		if (adv && load) begin
			fwd_s1 <= lit || issue_fwd;
			fwd_byte_s1 <= lit ? cmd.data : plain_byte;
			vld_s1 <= issue_vld;
			run_end_s1 <= lit ? 1'b1 : (!start && (left_q == LEN_W'(1)));
			final_s1 <= lit ? cmd.last : (!start && final_q && (left_q == LEN_W'(1)));
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_DEPTH)
		else $error("window fill count above depth");

	a_copy_has_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(left_q != '0) |-> out_valid_q)
		else $error("copy pending without a byte in the output stage");

	a_match_emits: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (out_valid_q && !run_end_s1))
		else $error("match start did not present its first byte");

	a_final_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && run_end_s1 && final_s1) |=> (wp_q == WP_RESET && fill_q == '0))
		else $error("window state not returned to reset after final byte");

endmodule

### design/lzss_window_decoder_core.sv
// LZSS decoder with a 4096-byte history window, one compressed byte per transaction.
// Flag and first match bytes produce no output; a literal appears in the cycle after acceptance.
// A match of N bytes (N at most 18) gives its first byte in the cycle after acceptance,
// then one per cycle through the single window read port while the output is not stalled;
// input is held while the last byte of a final-marked item waits and the window pointer rewinds.
// Reset is immediate: window reads as spaces through a fill count, no clearing pass.
module lzss_window_decoder_core
	import lzwd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	lzwd_in_if.sink compressed,
	lzwd_out_if.source decoded
);

	tok_cmd_t cmd;
	ram_req_t ram_req;
	logic [7:0] ram_rdata;
	logic take;

	lzwd_token_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.code_byte(compressed.code_byte),
		.final_byte(compressed.final_byte),
		.take(take),
		.cmd(cmd)
	);

	lzwd_copy_engine u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.in_valid(compressed.valid),
		.in_ready(compressed.ready),
		.take(take),
		.out_valid(decoded.valid),
		.out_ready(decoded.ready),
		.plain_byte(decoded.plain_byte),
		.run_end(decoded.run_end),
		.ram_req(ram_req),
		.ram_rdata(ram_rdata)
	);

	lzwd_window_ram u_window (
		.clk(clk),
		.req(ram_req),
		.rdata(ram_rdata)
	);

endmodule
